[rtl/rks_pkg.sv]
package rks_pkg;

    // Byte and word widths of the framed image.
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 16;

    // Most result bytes that one input item can cause (header plus data).
    localparam int MAX_RES = 5;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;

    // Input item modes.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Result bytes of one input item, first byte in slot zero.
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        logic [MAX_RES-1:0][BYTE_W-1:0]    bytes;
    } t_result;

endpackage

[rtl/rks_frame_core.sv]
module rks_frame_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rks_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rks_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_accept,
    input  logic                          i_mode,
    input  logic [rks_pkg::BYTE_W-1:0]    i_data_byte,
    output rks_pkg::t_result              o_result
);
    import rks_pkg::*;

    logic [ADDR_W-1:0] r_origin;
    logic [ADDR_W-1:0] r_size;
    logic              r_open;
    logic [ADDR_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_prev;

    logic [ADDR_W-1:0] end_addr;
    logic [ADDR_W-1:0] sum_next;
    logic [BYTE_W-1:0] chk_hi;

    // Header end address, running sum with the held byte, and the high checksum.
    assign end_addr = r_origin + r_size - ADDR_W'(1);
    assign sum_next = r_sum + ADDR_W'(r_prev);
    assign chk_hi   = r_sum[ADDR_W-1:BYTE_W] + r_sum[BYTE_W-1:0];

    // Result bytes that the presented item would cause.
    always_comb begin
        o_result = '0;
        if (i_mode == MODE_DATA) begin
            if (!r_open) begin
                o_result.count    = CNT_W'(MAX_RES);
                o_result.bytes[0] = r_origin[BYTE_W-1:0];
                o_result.bytes[1] = r_origin[ADDR_W-1:BYTE_W];
                o_result.bytes[2] = end_addr[BYTE_W-1:0];
                o_result.bytes[3] = end_addr[ADDR_W-1:BYTE_W];
                o_result.bytes[4] = i_data_byte;
            end else begin
                o_result.count    = CNT_W'(1);
                o_result.bytes[0] = i_data_byte;
            end
        end else if (r_open) begin
            o_result.count    = CNT_W'(2);
            o_result.bytes[0] = sum_next[BYTE_W-1:0];
            o_result.bytes[1] = chk_hi;
        end
    end

    // Configuration registers and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_size   <= '0;
            r_open   <= 1'b0;
            r_sum    <= '0;
            r_prev   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ORIGIN) begin
                    r_origin <= i_cfg_data;
                end else if (i_cfg_index == CFG_SIZE) begin
                    r_size <= i_cfg_data;
                end
            end
            if (i_accept) begin
                if (i_mode == MODE_DATA) begin
                    r_open <= 1'b1;
                    r_sum  <= sum_next;
                    r_prev <= i_data_byte;
                end else begin
                    r_open <= 1'b0;
                    r_sum  <= '0;
                    r_prev <= '0;
                end
            end
        end
    end

endmodule

[rtl/rks_out_seq.sv]
module rks_out_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  rks_pkg::t_result           i_result,
    input  logic                       i_out_stall,
    output logic                       o_free,
    output logic                       o_out_valid,
    output logic [rks_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);
    import rks_pkg::*;

    logic [CNT_W-1:0]               r_cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] r_bytes;
    logic [CNT_W-1:0]               n_cnt;
    logic [MAX_RES-1:0][BYTE_W-1:0] n_bytes;
    logic                           xfer;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_byte  = r_bytes[0];
    assign o_last      = (r_cnt == CNT_W'(1));
    assign xfer        = o_out_valid && !i_out_stall;

    // A new item may load when nothing is held or the final byte leaves now.
    assign o_free = !o_out_valid || (o_last && xfer);

    // Load a new set of bytes, or shift one out on each transfer.
    always_comb begin
        n_cnt   = r_cnt;
        n_bytes = r_bytes;
        if (i_load) begin
            n_cnt   = i_result.count;
            n_bytes = i_result.bytes;
        end else if (xfer) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int i = 0; i < MAX_RES - 1; i++) begin
                n_bytes[i] = r_bytes[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_bytes <= n_bytes;
    end

endmodule

[rtl/rks_binary_framer.sv]
// RKS image framer: every input item is a data byte or an end-of-frame mark, and
// the block answers with the bytes of the framed image on the output channel.
// The first data byte of a frame comes after a four-byte header (start address and
// end address, low byte first), and an end mark closes an open frame with two
// checksum bytes; an end mark with no open frame gives no output. A data byte in an
// open frame gives one byte, so the stream runs at one item per cycle unless
// stalled. A data byte that opens a frame gives five bytes and an end mark two,
// shifted out one byte per unstalled cycle; the next item is taken in the cycle
// the last byte of the previous one transfers. Configuration registers are written
// through a port that is always ready; write them only between frames.
module rks_binary_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rks_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rks_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [rks_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rks_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_last
);
    import rks_pkg::*;

    t_result result;
    logic    free;
    logic    in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !free;
    assign in_acc      = i_in_valid && free;

    // Frame state, header and checksum formation.
    rks_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_acc),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .o_result    (result)
    );

    // Output register that shifts the result bytes out one per transfer.
    rks_out_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_acc),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

`ifndef SYNTH
    // An item is taken while bytes are held only as the final one transfers.
    a_accept_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && o_out_valid |-> o_last && !i_out_stall)
        else $error("input accepted while result bytes still pending");

    // A data byte always produces output in the next cycle.
    a_data_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_mode == MODE_DATA) |=> o_out_valid)
        else $error("data byte produced no output");

    // After the final byte leaves with nothing new taken, the output goes quiet.
    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !i_out_stall && !in_acc |=> !o_out_valid)
        else $error("output still valid after final transfer");
`endif

endmodule
